[src/skaf_pkg.sv]
// ============================================================================
// skaf_pkg : shared types and constants of the altitude Kalman filter
// Phase tuning tables, fixed-point limits, sequencer states and the bit
// layout of the result transfer.
// ============================================================================
package skaf_pkg;

    // Request kinds carried in the slave-side tuser.
    typedef enum logic [1:0] {
        REQ_PREDICT = 2'd0,
        REQ_UPDATE  = 2'd1,
        REQ_RESET   = 2'd2,
        REQ_PHASE   = 2'd3
    } t_req;

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_EXEC  = 8'b0000_0010,
        ST_MULPR = 8'b0000_0100,
        ST_DIVK  = 8'b0000_1000,
        ST_MULC  = 8'b0001_0000,
        ST_DIVP  = 8'b0010_0000,
        ST_WB    = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } t_state;

    // Fixed-point limits (altitude Q20.12, variance Q16.16).
    localparam logic signed [31:0] ALT_FLOOR_GATE   = -32'sd4096000;
    localparam logic signed [31:0] ALT_FLOOR_HEALTH = -32'sd8192000;
    localparam logic [31:0]        VAR_RESET        = 32'd6553600;
    localparam logic [31:0]        VAR_FLOOR        = 32'd655;
    localparam logic [7:0]         FAIL_LIMIT       = 8'd10;
    localparam logic [30:0]        MAX_ALT_RESET    = 31'd122880000;
    localparam logic [31:0]        MAX_VAR_RESET    = 32'd655360000;

    // Quotient bits produced by the shared restoring divider.
    localparam int DIV_STEPS = 24;

    // Configuration register indexes.
    localparam logic CFG_MAX_ALT = 1'b0;
    localparam logic CFG_MAX_VAR = 1'b1;

    // Result tdata layout.
    localparam int OUT_ACC_LSB  = 0;
    localparam int OUT_ALT_LSB  = 1;
    localparam int OUT_VAR_LSB  = 33;
    localparam int OUT_FAIL_LSB = 65;
    localparam int OUT_HLT_LSB  = 73;
    localparam int OUT_WIDTH    = 80;

    // Process noise Q per phase, Q16.16.
    function automatic logic [18:0] phase_q(input logic [1:0] ph);
        logic [18:0] q;
        case (ph)
            2'd0:    q = 19'd6554;
            2'd1:    q = 19'd327680;
            2'd2:    q = 19'd65536;
            default: q = 19'd196608;
        endcase
        return q;
    endfunction

    // Measurement noise R per phase, Q16.16.
    function automatic logic [18:0] phase_r(input logic [1:0] ph);
        logic [18:0] r;
        case (ph)
            2'd0:    r = 19'd131072;
            2'd1:    r = 19'd327680;
            2'd2:    r = 19'd196608;
            default: r = 19'd262144;
        endcase
        return r;
    endfunction

    // Jump limit per phase, Q20.12 metres.
    function automatic logic [18:0] phase_jump(input logic [1:0] ph);
        logic [18:0] j;
        case (ph)
            2'd0:    j = 19'd81920;
            2'd1:    j = 19'd409600;
            2'd2:    j = 19'd204800;
            default: j = 19'd307200;
        endcase
        return j;
    endfunction

endpackage

[src/scalar_kalman_altitude_filter.sv]
// ============================================================================
// scalar_kalman_altitude_filter : scalar Kalman altitude estimator
// Keeps an altitude estimate and its variance, gates measurements by range
// and jump size, and runs the scalar update on one shared multiplier and
// one shared restoring divider under a small sequencer.
// ============================================================================
//
//  Channel   Direction  Handshake                 Payload
//  --------  ---------  ------------------------  --------------------------------
//  s stream  in         i_s_tvalid / o_s_tready   tuser: req_type; tdata: value,
//                                                 has_initial, phase
//  m stream  out        o_m_tvalid / i_m_tready   tdata: accepted, altitude,
//                                                 variance, failure count, healthy
//  cfg       in         i_cfg_we (no wait)        i_cfg_idx, i_cfg_wdata
//
// A predict, reset or phase transfer runs through the execute state to a
// loaded result register, and so does a rejected measurement. A measurement
// that passes the gate first runs the two 24-step divisions (gain, then new
// variance), one quotient bit per cycle on the shared divider. The input is
// ready only while the sequencer is idle; a finished result may wait in the
// output register while the next item is taken, and the sequencer holds in
// its final state only if that register is still full.
// Reset is synchronous and active low; it restores the filter state and the
// two limit registers.
module scalar_kalman_altitude_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave side.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [1:0]  i_s_tuser,   // [1:0] req_type
    input  logic [39:0] i_s_tdata,   // [31:0] value, [32] has_initial,
                                     // [34:33] phase, [39:35] zero
    // Master side.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata,   // [0] accepted, [32:1] filtered_altitude,
                                     // [64:33] variance, [72:65] failure_count,
                                     // [73] healthy, [79:74] zero
    // Configuration writes.
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);

    skaf_pkg::t_state r_state, n_state;

    // Captured request.
    skaf_pkg::t_req     r_req;
    logic signed [31:0] r_val;
    logic               r_init;
    logic [1:0]         r_ph;

    // Limit registers.
    logic [30:0] r_max_alt;
    logic [31:0] r_max_var;

    // Filter state.
    logic signed [31:0] r_alt;
    logic [31:0]        r_var;
    logic signed [31:0] r_last;
    logic [7:0]         r_fail;
    logic [1:0]         r_phase;
    logic               r_seen;
    logic               r_acc;

    // Update working registers.
    logic [32:0]        r_s;       // P + R
    logic signed [32:0] r_y;       // innovation
    logic [31:0]        r_mag;     // |innovation|
    logic [51:0]        r_num2;    // P*R + S/2
    logic [31:0]        r_corr;    // rounded |y|*K
    logic [32:0]        r_rem;     // divider partial remainder
    logic [23:0]        r_dlo;     // dividend low bits, then quotient
    logic [4:0]         r_cnt;

    // Result register.
    logic                               r_out_valid;
    logic [skaf_pkg::OUT_WIDTH-1:0]     r_out_data;

    logic        w_in_xfer;
    logic        w_out_load;
    logic [18:0] w_q, w_r, w_jump;

    assign w_q    = skaf_pkg::phase_q(r_phase);
    assign w_r    = skaf_pkg::phase_r(r_phase);
    assign w_jump = skaf_pkg::phase_jump(r_phase);

    assign o_s_tready = (r_state == skaf_pkg::ST_IDLE);
    assign w_in_xfer  = i_s_tvalid && o_s_tready;
    assign w_out_load = (r_state == skaf_pkg::ST_DONE) && (!r_out_valid || i_m_tready);

    // Measurement gate: range check, then jump check once anything was accepted.
    logic               w_below, w_above, w_jump_bad, w_gate_ok;
    logic signed [32:0] w_diff, w_jump_s;
    assign w_below    = r_val < skaf_pkg::ALT_FLOOR_GATE;
    assign w_above    = r_val > $signed({1'b0, r_max_alt});
    assign w_diff     = $signed({r_val[31], r_val}) - $signed({r_last[31], r_last});
    assign w_jump_s   = $signed({14'd0, w_jump});
    assign w_jump_bad = r_seen && ((w_diff > w_jump_s) || (w_diff < -w_jump_s));
    assign w_gate_ok  = !w_below && !w_above && !w_jump_bad;

    // Predict: variance plus Q, saturating.
    logic [32:0] w_var_pred;
    assign w_var_pred = {1'b0, r_var} + {14'd0, w_q};

    // Shared multiplier: P*R in ST_MULPR, |y|*K otherwise.
    logic [31:0] w_mul_a;
    logic [23:0] w_mul_b;
    logic [55:0] w_prod, w_corr_sum;
    always_comb begin
        if (r_state == skaf_pkg::ST_MULPR) begin
            w_mul_a = r_var;
            w_mul_b = {5'd0, w_r};
        end else begin
            w_mul_a = r_mag;
            w_mul_b = r_dlo;
        end
    end
    assign w_prod     = {24'd0, w_mul_a} * {32'd0, w_mul_b};
    assign w_corr_sum = w_prod + 56'h80_0000;

    // Gain dividend: (P << 24) + S/2.
    logic [56:0] w_num_k;
    assign w_num_k = {1'b0, r_var, 24'd0} + {25'd0, r_s[32:1]};

    // Shared restoring divider step against S.
    logic [33:0] w_rem_sh;
    logic [34:0] w_sub;
    logic        w_ge;
    assign w_rem_sh = {r_rem, r_dlo[23]};
    assign w_sub    = {1'b0, w_rem_sh} - {2'b00, r_s};
    assign w_ge     = !w_sub[34];

    logic w_div_last;
    assign w_div_last = (r_cnt == 5'(skaf_pkg::DIV_STEPS - 1));

    // Write-back: estimate plus signed correction, saturated to 32 bits.
    logic signed [33:0] w_na;
    logic signed [31:0] w_na_sat;
    always_comb begin
        if (r_y[32]) begin
            w_na = $signed({{2{r_alt[31]}}, r_alt}) - $signed({2'b00, r_corr});
        end else begin
            w_na = $signed({{2{r_alt[31]}}, r_alt}) + $signed({2'b00, r_corr});
        end
        if (w_na > 34'sd2147483647) begin
            w_na_sat = 32'sh7FFF_FFFF;
        end else if (w_na < -34'sd2147483648) begin
            w_na_sat = 32'sh8000_0000;
        end else begin
            w_na_sat = w_na[31:0];
        end
    end

    // Health of the current state.
    logic w_healthy;
    assign w_healthy = (r_fail <= skaf_pkg::FAIL_LIMIT) && (r_var != 32'd0) &&
                       (r_var <= r_max_var) && (r_alt >= skaf_pkg::ALT_FLOOR_HEALTH) &&
                       (r_alt <= $signed({1'b0, r_max_alt}));

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            skaf_pkg::ST_IDLE: begin
                if (w_in_xfer) n_state = skaf_pkg::ST_EXEC;
            end
            skaf_pkg::ST_EXEC: begin
                if (r_req == skaf_pkg::REQ_UPDATE && w_gate_ok) begin
                    n_state = skaf_pkg::ST_MULPR;
                end else begin
                    n_state = skaf_pkg::ST_DONE;
                end
            end
            skaf_pkg::ST_MULPR: n_state = skaf_pkg::ST_DIVK;
            skaf_pkg::ST_DIVK: begin
                if (w_div_last) n_state = skaf_pkg::ST_MULC;
            end
            skaf_pkg::ST_MULC: n_state = skaf_pkg::ST_DIVP;
            skaf_pkg::ST_DIVP: begin
                if (w_div_last) n_state = skaf_pkg::ST_WB;
            end
            skaf_pkg::ST_WB: n_state = skaf_pkg::ST_DONE;
            skaf_pkg::ST_DONE: begin
                if (w_out_load) n_state = skaf_pkg::ST_IDLE;
            end
            default: n_state = skaf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= skaf_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_max_alt   <= skaf_pkg::MAX_ALT_RESET;
            r_max_var   <= skaf_pkg::MAX_VAR_RESET;
            r_alt       <= '0;
            r_var       <= skaf_pkg::VAR_RESET;
            r_last      <= '0;
            r_fail      <= '0;
            r_phase     <= '0;
            r_seen      <= 1'b0;
            r_acc       <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    skaf_pkg::CFG_MAX_ALT: r_max_alt <= i_cfg_wdata[30:0];
                    skaf_pkg::CFG_MAX_VAR: r_max_var <= i_cfg_wdata;
                    default: ;
                endcase
            end

            if (w_in_xfer) begin
                r_req  <= skaf_pkg::t_req'(i_s_tuser);
                r_val  <= $signed(i_s_tdata[31:0]);
                r_init <= i_s_tdata[32];
                r_ph   <= i_s_tdata[34:33];
            end

            unique case (r_state)
                skaf_pkg::ST_EXEC: begin
                    r_acc <= 1'b0;
                    unique case (r_req)
                        skaf_pkg::REQ_PREDICT: begin
                            r_var <= w_var_pred[32] ? 32'hFFFF_FFFF : w_var_pred[31:0];
                        end
                        skaf_pkg::REQ_UPDATE: begin
                            if (w_gate_ok) begin
                                r_s <= {1'b0, r_var} + {14'd0, w_r};
                                r_y <= $signed({r_val[31], r_val}) -
                                       $signed({r_alt[31], r_alt});
                            end else if (r_fail != 8'hFF) begin
                                r_fail <= r_fail + 8'd1;
                            end
                        end
                        skaf_pkg::REQ_RESET: begin
                            r_alt   <= r_init ? r_val : 32'sd0;
                            r_last  <= r_init ? r_val : 32'sd0;
                            r_var   <= skaf_pkg::VAR_RESET;
                            r_phase <= '0;
                            r_fail  <= '0;
                        end
                        skaf_pkg::REQ_PHASE: r_phase <= r_ph;
                        default: ;
                    endcase
                end
                skaf_pkg::ST_MULPR: begin
                    r_mag  <= r_y[32] ? 32'(-r_y) : r_y[31:0];
                    r_num2 <= w_prod[51:0] + {20'd0, r_s[32:1]};
                    r_rem  <= w_num_k[56:24];
                    r_dlo  <= w_num_k[23:0];
                    r_cnt  <= '0;
                end
                skaf_pkg::ST_DIVK, skaf_pkg::ST_DIVP: begin
                    r_rem <= w_ge ? w_sub[32:0] : w_rem_sh[32:0];
                    r_dlo <= {r_dlo[22:0], w_ge};
                    r_cnt <= r_cnt + 5'd1;
                end
                skaf_pkg::ST_MULC: begin
                    // r_dlo holds the gain here; it is replaced by the next dividend.
                    r_corr <= w_corr_sum[55:24];
                    r_rem  <= {5'd0, r_num2[51:24]};
                    r_dlo  <= r_num2[23:0];
                    r_cnt  <= '0;
                end
                skaf_pkg::ST_WB: begin
                    r_alt  <= w_na_sat;
                    r_var  <= ({8'd0, r_dlo} < skaf_pkg::VAR_FLOOR) ?
                              skaf_pkg::VAR_FLOOR : {8'd0, r_dlo};
                    r_last <= r_val;
                    r_fail <= '0;
                    r_seen <= 1'b1;
                    r_acc  <= 1'b1;
                end
                default: ;
            endcase

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= {6'd0, w_healthy, r_fail, r_var, r_alt, r_acc};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

[src/skaf_checker.sv]
// ============================================================================
// skaf_checker : port-level checks of the altitude Kalman filter
// Watches the stream ports and flags handshake or result inconsistencies.
// ============================================================================
module skaf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [79:0] o_m_tdata
);

    logic        w_acc;
    logic [31:0] w_var;
    logic [7:0]  w_fail;
    assign w_acc  = o_m_tdata[skaf_pkg::OUT_ACC_LSB];
    assign w_var  = o_m_tdata[skaf_pkg::OUT_VAR_LSB +: 32];
    assign w_fail = o_m_tdata[skaf_pkg::OUT_FAIL_LSB +: 8];

    // The filter works on one item at a time.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input ready right after a transfer");

    // An applied measurement clears the failure run.
    a_acc_clears_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && w_acc) |-> (w_fail == 8'd0))
        else $error("accepted update with nonzero failure count");

    // An applied measurement leaves the variance at or above the floor.
    a_acc_var_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && w_acc) |-> (w_var >= skaf_pkg::VAR_FLOOR))
        else $error("variance below floor after update");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result changed while stalled");

endmodule

bind scalar_kalman_altitude_filter skaf_checker u_skaf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

[bench/skaf_filter_checker.sv]
// ============================================================================
// skaf_filter_checker : result checker for the scalar altitude Kalman filter
// Watches the request, result and configuration channels, keeps its own
// copy of the filter state, predicts every result word and compares it.
// ============================================================================
module skaf_filter_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [1:0]  i_s_tuser,   // [1:0] req_type
    input  logic [39:0] i_s_tdata,   // [31:0] value, [32] has_initial, [34:33] phase
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [79:0] i_m_tdata,   // [0] accepted, [32:1] altitude, [64:33] variance,
                                     // [72:65] failure_count, [73] healthy
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    output int          o_mismatches,
    output int          o_outstanding
);

    localparam logic signed [63:0] GATE_FLOOR   = -64'sd4096000;
    localparam logic signed [63:0] HEALTH_FLOOR = -64'sd8192000;
    localparam logic [31:0]        VAR_START    = 32'd6553600;
    localparam logic [63:0]        VAR_MIN      = 64'd655;
    localparam logic [7:0]         FAIL_MAX_OK  = 8'd10;

    typedef struct packed {
        logic        accepted;
        logic [31:0] altitude;
        logic [31:0] variance;
        logic [7:0]  failures;
        logic        healthy;
    } t_filter_report;

    t_filter_report predicted_reports[$];

    logic signed [31:0] est_alt;
    logic [31:0]        est_var;
    logic signed [31:0] last_meas;
    logic [7:0]         fail_run;
    logic [1:0]         cur_phase;
    logic               seen_meas;
    logic [30:0]        alt_limit;
    logic [31:0]        var_limit;
    int                 mismatches;
    int                 report_no;

    function automatic logic [63:0] process_noise(input logic [1:0] ph);
        case (ph)
            2'd0:    return 64'd6554;
            2'd1:    return 64'd327680;
            2'd2:    return 64'd65536;
            default: return 64'd196608;
        endcase
    endfunction

    function automatic logic [63:0] sensor_noise(input logic [1:0] ph);
        case (ph)
            2'd0:    return 64'd131072;
            2'd1:    return 64'd327680;
            2'd2:    return 64'd196608;
            default: return 64'd262144;
        endcase
    endfunction

    function automatic logic signed [63:0] jump_limit(input logic [1:0] ph);
        case (ph)
            2'd0:    return 64'sd81920;
            2'd1:    return 64'sd409600;
            2'd2:    return 64'sd204800;
            default: return 64'sd307200;
        endcase
    endfunction

    // Gate the measurement, then run the scalar update in 64-bit arithmetic.
    function automatic logic apply_measurement(input logic signed [31:0] meas);
        logic signed [63:0] m;
        logic signed [63:0] jump_len;
        logic signed [63:0] innov;
        logic signed [63:0] alt_wide;
        logic signed [63:0] ceiling;
        logic [63:0]        p;
        logic [63:0]        r;
        logic [63:0]        s;
        logic [63:0]        gain;
        logic [63:0]        mag;
        logic [63:0]        corr;
        logic [63:0]        next_var;
        m       = meas;
        ceiling = $signed({33'd0, alt_limit});
        if (m < GATE_FLOOR || m > ceiling)
            return 1'b0;
        if (seen_meas) begin
            jump_len = m - 64'(last_meas);
            if (jump_len < 0)
                jump_len = -jump_len;
            if (jump_len > jump_limit(cur_phase))
                return 1'b0;
        end
        p     = {32'd0, est_var};
        r     = sensor_noise(cur_phase);
        s     = p + r;
        gain  = ((p << 24) + s / 2) / s;
        alt_wide = est_alt;
        innov = m - alt_wide;
        mag   = (innov < 0) ? -innov : innov;
        corr  = (mag * gain + 64'd8388608) >> 24;
        alt_wide = (innov < 0) ? alt_wide - $signed(corr) : alt_wide + $signed(corr);
        if (alt_wide > 64'sd2147483647)
            alt_wide = 64'sd2147483647;
        if (alt_wide < -64'sd2147483648)
            alt_wide = -64'sd2147483648;
        est_alt  = alt_wide[31:0];
        next_var = (p * r + s / 2) / s;
        if (next_var < VAR_MIN)
            next_var = VAR_MIN;
        est_var   = next_var[31:0];
        last_meas = meas;
        fail_run  = 8'd0;
        seen_meas = 1'b1;
        return 1'b1;
    endfunction

    function automatic logic filter_healthy();
        logic signed [63:0] a;
        a = est_alt;
        if (fail_run > FAIL_MAX_OK)
            return 1'b0;
        if (est_var > var_limit || est_var == 32'd0)
            return 1'b0;
        if (a < HEALTH_FLOOR || a > $signed({33'd0, alt_limit}))
            return 1'b0;
        return 1'b1;
    endfunction

    // Advance the filter copy by one request and form the result it reports.
    function automatic t_filter_report run_filter_item(input skaf_pkg::t_req req,
                                                       input logic signed [31:0] value,
                                                       input logic has_init,
                                                       input logic [1:0] ph);
        t_filter_report rep;
        logic           took;
        logic [63:0]    grown;
        took = 1'b0;
        case (req)
            skaf_pkg::REQ_PREDICT: begin
                grown   = {32'd0, est_var} + process_noise(cur_phase);
                est_var = (grown > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : grown[31:0];
            end
            skaf_pkg::REQ_UPDATE: begin
                took = apply_measurement(value);
                if (!took && fail_run != 8'd255)
                    fail_run = fail_run + 8'd1;
            end
            skaf_pkg::REQ_RESET: begin
                est_alt   = has_init ? value : 32'sd0;
                last_meas = est_alt;
                est_var   = VAR_START;
                cur_phase = 2'd0;
                fail_run  = 8'd0;
            end
            default: begin
                cur_phase = ph;
            end
        endcase
        rep.accepted = took;
        rep.altitude = est_alt;
        rep.variance = est_var;
        rep.failures = fail_run;
        rep.healthy  = filter_healthy();
        return rep;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("skaf check: result %0d %s: got 0x%08h, predicted 0x%08h",
                 report_no, what, got, want);
    endtask

    task automatic check_report(input logic [79:0] word);
        t_filter_report want;
        if (predicted_reports.size() == 0) begin
            report_mismatch("arrived with nothing outstanding", 32'd1, 32'd0);
        end else begin
            want = predicted_reports.pop_front();
            if (word[skaf_pkg::OUT_ACC_LSB] !== want.accepted)
                report_mismatch("accepted", 32'(word[skaf_pkg::OUT_ACC_LSB]),
                                32'(want.accepted));
            if (word[skaf_pkg::OUT_ALT_LSB +: 32] !== want.altitude)
                report_mismatch("altitude", word[skaf_pkg::OUT_ALT_LSB +: 32],
                                want.altitude);
            if (word[skaf_pkg::OUT_VAR_LSB +: 32] !== want.variance)
                report_mismatch("variance", word[skaf_pkg::OUT_VAR_LSB +: 32],
                                want.variance);
            if (word[skaf_pkg::OUT_FAIL_LSB +: 8] !== want.failures)
                report_mismatch("failure count", 32'(word[skaf_pkg::OUT_FAIL_LSB +: 8]),
                                32'(want.failures));
            if (word[skaf_pkg::OUT_HLT_LSB] !== want.healthy)
                report_mismatch("healthy", 32'(word[skaf_pkg::OUT_HLT_LSB]),
                                32'(want.healthy));
        end
        report_no++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            est_alt   = 32'sd0;
            est_var   = VAR_START;
            last_meas = 32'sd0;
            fail_run  = 8'd0;
            cur_phase = 2'd0;
            seen_meas = 1'b0;
            alt_limit = 31'd122880000;
            var_limit = 32'd655360000;
            predicted_reports.delete();
        end else begin
            if (i_m_tvalid && i_m_tready)
                check_report(i_m_tdata);
            if (i_cfg_we) begin
                if (i_cfg_idx == skaf_pkg::CFG_MAX_ALT)
                    alt_limit = i_cfg_wdata[30:0];
                else
                    var_limit = i_cfg_wdata;
            end
            if (i_s_tvalid && i_s_tready)
                predicted_reports.push_back(run_filter_item(
                    skaf_pkg::t_req'(i_s_tuser), i_s_tdata[31:0], i_s_tdata[32],
                    i_s_tdata[34:33]));
        end
        o_mismatches  <= mismatches;
        o_outstanding <= predicted_reports.size();
    end

endmodule

[bench/scalar_kalman_altitude_filter_test.sv]
// ============================================================================
// scalar_kalman_altitude_filter_test : top of the altitude filter bench
// Drives requests, limit writes and result backpressure into the filter and
// leaves all prediction and comparison to the checker instantiated beside it.
// ============================================================================
module scalar_kalman_altitude_filter_test;

    // Gated measurements take longest; allow a margin beyond them at the end.
    localparam int SETTLE_CYCLES = 60;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;    // [1:0] req_type
    logic [39:0] s_tdata;    // [31:0] value, [32] has_initial, [34:33] phase, [39:35] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;    // [0] accepted, [32:1] altitude, [64:33] variance,
                             // [72:65] failure_count, [73] healthy, [79:74] zero
    logic        cfg_we;
    logic        cfg_idx;
    logic [31:0] cfg_wdata;
    int          mismatches;
    int          outstanding;

    // When set, neither the request side nor the result side idles.
    bit          steady;
    // Altitude that tracking measurements wander around; kept near the last
    // value the filter should have accepted so most updates pass the gate.
    longint      anchor;

    scalar_kalman_altitude_filter uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tuser   (s_tuser),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    skaf_filter_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tuser     (s_tuser),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_wdata   (cfg_wdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run, even if every request were
    // a gated measurement held up by result stalls.
    initial begin
        #50_000_000;
        $display("[scalar_kalman_altitude_filter] ERROR");
        $finish;
    end

    // The result side stalls about a quarter of the time unless steady.
    always @(posedge clk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 26);
    end

    // One request transfer. Random idle cycles come first, so gaps land on
    // every phase of the sequencer; valid then stays high until accepted.
    task automatic send_item(input skaf_pkg::t_req req, input logic [31:0] value,
                             input logic has_init, input logic [1:0] ph);
        while (!steady && $urandom_range(0, 99) < 26) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {5'd0, ph, has_init, value};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Sends a request whose unused fields carry random bits.
    task automatic send_noisy(input skaf_pkg::t_req req, input logic [31:0] value);
        send_item(req, value, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
    endtask

    // Stop requesting and hold off until every predicted result has been
    // transferred. The first edge lets the checker's count catch up with the
    // last request transfer.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] clamp_alt(input longint v, input longint lo,
                                              input longint hi);
        if (v < lo)
            return lo[31:0];
        if (v > hi)
            return hi[31:0];
        return v[31:0];
    endfunction

    // Mostly well-formed traffic: measurements tracking the anchor, with some
    // oversized jumps, out-of-range noise, predicts, phase changes and resets.
    task automatic run_random(input int count, input longint lo, input longint hi);
        int          pick;
        logic [31:0] v;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 48) begin
                v = clamp_alt(anchor + longint'($urandom_range(0, 147456)) - 73728, lo, hi);
                anchor = $signed(v);
                send_noisy(skaf_pkg::REQ_UPDATE, v);
            end else if (pick < 58) begin
                v = clamp_alt(anchor + longint'($urandom_range(0, 983040)) - 491520, lo, hi);
                send_noisy(skaf_pkg::REQ_UPDATE, v);
            end else if (pick < 68) begin
                send_noisy(skaf_pkg::REQ_UPDATE, $urandom);
            end else if (pick < 82) begin
                send_noisy(skaf_pkg::REQ_PREDICT, $urandom);
            end else if (pick < 92) begin
                send_noisy(skaf_pkg::REQ_PHASE, $urandom);
            end else if (pick < 97) begin
                send_item(skaf_pkg::REQ_RESET, anchor[31:0], 1'b1, 2'($urandom_range(0, 3)));
            end else begin
                anchor = 0;
                send_item(skaf_pkg::REQ_RESET, $urandom, 1'b0, 2'($urandom_range(0, 3)));
            end
        end
    endtask

    initial begin
        logic [31:0] lim;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = skaf_pkg::REQ_PREDICT;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_idx   = skaf_pkg::CFG_MAX_ALT;
        cfg_wdata = '0;
        steady    = 1'b0;
        anchor    = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset limits (30000 m, variance 10000).
        send_noisy(skaf_pkg::REQ_PREDICT, 32'h0);
        // The very first measurement skips the jump check however far it is.
        send_noisy(skaf_pkg::REQ_UPDATE, 32'sd4096000);
        send_noisy(skaf_pkg::REQ_UPDATE, 32'sd4136960);
        // Forty metres in the ground phase exceeds the twenty metre jump limit.
        send_noisy(skaf_pkg::REQ_UPDATE, 32'sd4300800);
        // Just below the lower gate, just above the upper limit, both rails.
        send_noisy(skaf_pkg::REQ_UPDATE, -32'sd4096001);
        send_noisy(skaf_pkg::REQ_UPDATE, 32'sd122880001);
        send_noisy(skaf_pkg::REQ_UPDATE, 32'h7FFF_FFFF);
        send_noisy(skaf_pkg::REQ_UPDATE, 32'h8000_0000);
        // Each flight phase with a predict and a measurement inside its limit.
        send_item(skaf_pkg::REQ_PHASE, $urandom, 1'b0, 2'd1);
        send_noisy(skaf_pkg::REQ_PREDICT, $urandom);
        send_noisy(skaf_pkg::REQ_UPDATE, 32'sd4423680);
        send_item(skaf_pkg::REQ_PHASE, $urandom, 1'b1, 2'd2);
        send_noisy(skaf_pkg::REQ_PREDICT, $urandom);
        send_noisy(skaf_pkg::REQ_UPDATE, 32'sd4546560);
        send_item(skaf_pkg::REQ_PHASE, $urandom, 1'b0, 2'd3);
        send_noisy(skaf_pkg::REQ_PREDICT, $urandom);
        send_noisy(skaf_pkg::REQ_UPDATE, 32'sd4669440);
        // Reset without an initial value loads zero whatever the value field holds.
        send_item(skaf_pkg::REQ_RESET, 32'hFFFF_FFFF, 1'b0, 2'd3);
        // Measurements exactly on the lower gate and on the upper limit.
        send_item(skaf_pkg::REQ_RESET, -32'sd4055040, 1'b1, 2'd0);
        send_noisy(skaf_pkg::REQ_UPDATE, -32'sd4096000);
        send_item(skaf_pkg::REQ_RESET, 32'sd122875904, 1'b1, 2'd0);
        send_noisy(skaf_pkg::REQ_UPDATE, 32'sd122880000);
        // Estimates on and beyond the health floor of -2000 m.
        send_item(skaf_pkg::REQ_RESET, -32'sd8192000, 1'b1, 2'd2);
        send_item(skaf_pkg::REQ_RESET, 32'h8000_0000, 1'b1, 2'd1);
        drain();

        // Widest limits: altitudes up to the top rail, any variance is healthy.
        cfg_write(skaf_pkg::CFG_MAX_ALT, 32'h7FFF_FFFF);
        cfg_write(skaf_pkg::CFG_MAX_VAR, 32'hFFFF_FFFF);
        send_item(skaf_pkg::REQ_RESET, 32'h7FFF_F000, 1'b1, 2'd0);
        send_noisy(skaf_pkg::REQ_UPDATE, 32'h7FFF_FFFF);
        anchor = 64'sh7FFF_FFFF;
        run_random(80, -4096000, 64'sh7FFF_FFFF);
        // A run of ascent predicts pushes the variance up in large steps.
        send_item(skaf_pkg::REQ_PHASE, $urandom, 1'b0, 2'd1);
        for (int n = 0; n < 20; n++)
            send_noisy(skaf_pkg::REQ_PREDICT, $urandom);
        drain();

        // Zero limits: nothing is healthy, only non-positive altitudes pass.
        cfg_write(skaf_pkg::CFG_MAX_ALT, 32'd0);
        cfg_write(skaf_pkg::CFG_MAX_VAR, 32'd0);
        anchor = -2048000;
        send_item(skaf_pkg::REQ_RESET, anchor[31:0], 1'b1, 2'd0);
        run_random(60, -4096000, 0);
        // Rejections past the health threshold and on into the counter's ceiling.
        for (int n = 0; n < 260; n++)
            send_noisy(skaf_pkg::REQ_UPDATE,
                       32'(-32'sd4096001 - int'($urandom_range(0, 1000000))));
        send_item(skaf_pkg::REQ_RESET, anchor[31:0], 1'b1, 2'd0);
        drain();

        // Random limits, with a stretch where neither side ever idles.
        lim = $urandom_range(4096000, 400000000);
        cfg_write(skaf_pkg::CFG_MAX_ALT, lim);
        cfg_write(skaf_pkg::CFG_MAX_VAR, $urandom_range(32'd655, 32'hFFFF_FFFF));
        anchor = lim / 2;
        send_item(skaf_pkg::REQ_RESET, anchor[31:0], 1'b1, 2'd0);
        run_random(50, -4096000, lim);
        steady = 1'b1;
        run_random(60, -4096000, lim);
        steady = 1'b0;
        run_random(50, -4096000, lim);
        drain();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("[scalar_kalman_altitude_filter] OK");
        else
            $display("[scalar_kalman_altitude_filter] ERROR");
        $finish;
    end

endmodule
